// File: rtl/rch_pkg.sv
package rch_pkg;

  localparam int unsigned MATRIX_ROWS    = 6;
  localparam int unsigned MATRIX_COLUMNS = 4;
  localparam int unsigned LATCH_SIDE     = 8;

  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned NUM_POS   = MATRIX_ROWS * MATRIX_COLUMNS;
  localparam int unsigned POS_W     = (NUM_POS > 1) ? $clog2(NUM_POS) : 1;
  localparam int unsigned NUM_ADDR  = LATCH_SIDE * LATCH_SIDE;
  localparam int unsigned ADDR_W    = $clog2(NUM_ADDR);
  localparam int unsigned COUNT_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [ADDR_W-1:0]  SWEEP_LAST = ADDR_W'(NUM_ADDR - 1);

  typedef enum logic [1:0] {
    ACT_PRESS       = 2'd0,
    ACT_RELEASE     = 2'd1,
    ACT_RELEASE_ALL = 2'd2
  } action_e;

  // controller to datapath
  typedef struct packed {
    logic item_load;
    logic clear_all;
    logic sweep_step;
  } rch_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
  } rch_status_t;

endpackage

// File: rtl/refcounted_crosspoint_hold_unit.sv
// crosspoint hold unit: one saturating hold count per matrix position
//
// input: a transaction is taken at a rising edge with start high and busy low;
// action_i, row_i and column_i are sampled at that edge
// output: each result is driven for one cycle with strobe_o high; the
// receiver cannot stall, so results must be taken as they appear
//
// press and release: one result in the cycle after the transaction, and a new
// transaction may be taken at every edge (one per cycle); the count update is
// a read-modify-write of a flip-flop count array, written at the accepting edge
// release all: clears all counts at once, then a 6-bit sweep counter emits
// 64 open commands, one per cycle, once the transaction is taken; busy is
// high while the sweep runs, so the next transaction can be taken only
// after busy has fallen at the end of the sweep
//
// reset: all hold counts zero, no result pending, busy low
module refcounted_crosspoint_hold_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [rch_pkg::ROW_W-1:0]   row_i,
  input  logic [rch_pkg::COL_W-1:0]   column_i,
  output logic                        strobe_o,
  output logic                        accepted_o,
  output logic                        write_valid_o,
  output logic [rch_pkg::ADDR_W-1:0]  switch_address_o,
  output logic                        close_o,
  output logic                        last_o
);
  import rch_pkg::*;

  rch_cmd_t    cmd;
  rch_status_t status;

  rch_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  rch_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .status_o         (status),
    .strobe_o         (strobe_o),
    .accepted_o       (accepted_o),
    .write_valid_o    (write_valid_o),
    .switch_address_o (switch_address_o),
    .close_o          (close_o),
    .last_o           (last_o)
  );

endmodule

// File: rtl/rch_ctrl.sv
module rch_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [1:0]           action_i,
  input  rch_pkg::rch_status_t status_i,
  output rch_pkg::rch_cmd_t    cmd_o,
  output logic                 busy
);
  import rch_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   accept;
  logic   is_release_all;

  assign accept         = start && !busy_q;
  assign is_release_all = (action_i == ACT_RELEASE_ALL);

  always_comb begin
    cmd_o.item_load  = accept;
    cmd_o.clear_all  = accept && is_release_all;
    cmd_o.sweep_step = (state_q == ST_SWEEP);
  end

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_release_all) begin
          state_d = ST_SWEEP;
          busy_d  = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
          busy_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

  // busy flag tracks the sweep state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q == ST_SWEEP))
    else $error("busy out of step with state");

  // sweep ends only after its last address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(status_i.sweep_last))
    else $error("sweep ended early");

  // release all always starts a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_all |=> busy_q)
    else $error("release all did not start sweep");

endmodule

// File: rtl/rch_datapath.sv
module rch_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rch_pkg::rch_cmd_t            cmd_i,
  input  logic [1:0]                   action_i,
  input  logic [rch_pkg::ROW_W-1:0]    row_i,
  input  logic [rch_pkg::COL_W-1:0]    column_i,
  output rch_pkg::rch_status_t         status_o,
  output logic                         strobe_o,
  output logic                         accepted_o,
  output logic                         write_valid_o,
  output logic [rch_pkg::ADDR_W-1:0]   switch_address_o,
  output logic                         close_o,
  output logic                         last_o
);
  import rch_pkg::*;

  logic [COUNT_W-1:0] counts_q [NUM_POS];
  logic [ADDR_W-1:0]  sweep_idx_q;

  logic                strobe_q;
  logic                accepted_q;
  logic                write_valid_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                close_q;
  logic                last_q;

  logic                in_range;
  logic                is_press;
  logic                is_release;
  logic [POS_W-1:0]    pos;
  logic [ADDR_W-1:0]   item_addr;
  logic [COUNT_W-1:0]  cnt_rd;
  logic [COUNT_W-1:0]  cnt_new;
  logic                cnt_we;
  logic                item_accepted;
  logic                item_wv;
  logic                item_close;

  assign in_range   = ({1'b0, row_i} < (ROW_W + 1)'(MATRIX_ROWS)) &&
                      ({1'b0, column_i} < (COL_W + 1)'(MATRIX_COLUMNS));
  assign is_press   = (action_i == ACT_PRESS);
  assign is_release = (action_i == ACT_RELEASE);
  assign pos        = POS_W'(32'(row_i) * MATRIX_COLUMNS + 32'(column_i));
  assign item_addr  = ADDR_W'(32'(row_i) * LATCH_SIDE + 32'(column_i));
  assign cnt_rd     = in_range ? counts_q[pos] : '0;

  // per item read-modify-write of one count
  always_comb begin
    cnt_new       = cnt_rd;
    cnt_we        = 1'b0;
    item_accepted = 1'b0;
    item_wv       = 1'b0;
    item_close    = 1'b0;
    if (in_range && is_press) begin
      item_accepted = 1'b1;
      item_wv       = (cnt_rd == '0);
      item_close    = (cnt_rd == '0);
      cnt_we        = (cnt_rd != COUNT_MAX);
      cnt_new       = cnt_rd + COUNT_W'(1);
    end else if (in_range && is_release) begin
      item_accepted = 1'b1;
      cnt_we        = (cnt_rd != '0);
      cnt_new       = cnt_rd - COUNT_W'(1);
      item_wv       = (cnt_rd == COUNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (cmd_i.clear_all) begin
      for (int i = 0; i < NUM_POS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (cmd_i.item_load && cnt_we) begin
      counts_q[pos] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q    <= 1'b0;
      sweep_idx_q <= '0;
    end else begin
      strobe_q <= (cmd_i.item_load && !cmd_i.clear_all) || cmd_i.sweep_step;
      if (cmd_i.clear_all) begin
        sweep_idx_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_idx_q <= sweep_idx_q + ADDR_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      accepted_q    <= 1'b1;
      write_valid_q <= 1'b1;
      addr_q        <= sweep_idx_q;
      close_q       <= 1'b0;
      last_q        <= (sweep_idx_q == SWEEP_LAST);
    end else if (cmd_i.item_load) begin
      accepted_q    <= item_accepted;
      write_valid_q <= item_wv;
      addr_q        <= item_wv ? item_addr : '0;
      close_q       <= item_close;
      last_q        <= 1'b1;
    end
  end

  assign status_o.sweep_last = (sweep_idx_q == SWEEP_LAST);

  assign strobe_o         = strobe_q;
  assign accepted_o       = accepted_q;
  assign write_valid_o    = write_valid_q;
  assign switch_address_o = addr_q;
  assign close_o          = close_q;
  assign last_o           = last_q;

  // rejected transaction never carries a latch command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !accepted_q |-> !write_valid_q && !close_q && last_q)
    else $error("rejected transaction with latch command");

  // final sweep step gives the last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step && status_o.sweep_last |=> strobe_q && last_q && !close_q)
    else $error("sweep end not marked last");

  // release all clears every count; checked on the first and last count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> (counts_q[0] == '0) && (counts_q[NUM_POS-1] == '0))
    else $error("counts not cleared");

  // no item load while sweeping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |-> !cmd_i.item_load)
    else $error("item load during sweep");

endmodule

// File: tb/sv/refcounted_crosspoint_hold_unit_tb.sv
module refcounted_crosspoint_hold_unit_tb;
  import rch_pkg::*;

  localparam logic [1:0]  ACT_UNDEFINED  = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 80;

  typedef struct {
    logic [1:0]       action;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    int unsigned      gap_pct;
  } key_event_t;

  typedef struct {
    logic              accepted;
    logic              write_valid;
    logic [ADDR_W-1:0] switch_address;
    logic              close;
    logic              last;
  } latch_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        action_i = '0;
  logic [ROW_W-1:0]  row_i = '0;
  logic [COL_W-1:0]  column_i = '0;
  logic              strobe_o;
  logic              accepted_o;
  logic              write_valid_o;
  logic [ADDR_W-1:0] switch_address_o;
  logic              close_o;
  logic              last_o;

  key_event_t        pending_events[$];
  latch_result_t     expected_commands[$];
  logic [COUNT_W-1:0] hold_count[NUM_POS];
  logic              took_event = 1'b0;
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;

  refcounted_crosspoint_hold_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .strobe_o         (strobe_o),
    .accepted_o       (accepted_o),
    .write_valid_o    (write_valid_o),
    .switch_address_o (switch_address_o),
    .close_o          (close_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void predict_latch_commands(logic [1:0] act, logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c);
    latch_result_t res;
    int unsigned   pos;
    int unsigned   k;
    logic          was_zero;
    res.accepted       = 1'b0;
    res.write_valid    = 1'b0;
    res.switch_address = '0;
    res.close          = 1'b0;
    res.last           = 1'b1;
    if (act == ACT_RELEASE_ALL) begin
      for (k = 0; k < NUM_POS; k++) hold_count[k] = '0;
      for (k = 0; k < NUM_ADDR; k++) begin
        res.accepted       = 1'b1;
        res.write_valid    = 1'b1;
        res.switch_address = ADDR_W'(k);
        res.close          = 1'b0;
        res.last           = (k == NUM_ADDR - 1);
        expected_commands.push_back(res);
      end
    end else if ((act == ACT_PRESS || act == ACT_RELEASE) &&
                 r < MATRIX_ROWS && c < MATRIX_COLUMNS) begin
      pos = r * MATRIX_COLUMNS + c;
      res.accepted = 1'b1;
      if (act == ACT_PRESS) begin
        was_zero = (hold_count[pos] == '0);
        if (hold_count[pos] != COUNT_MAX) hold_count[pos] = hold_count[pos] + 1'b1;
        if (was_zero) begin
          res.write_valid    = 1'b1;
          res.switch_address = ADDR_W'(r * LATCH_SIDE + c);
          res.close          = 1'b1;
        end
      end else if (hold_count[pos] != '0) begin
        hold_count[pos] = hold_count[pos] - 1'b1;
        if (hold_count[pos] == '0) begin
          res.write_valid    = 1'b1;
          res.switch_address = ADDR_W'(r * LATCH_SIDE + c);
        end
      end
      expected_commands.push_back(res);
    end else begin
      expected_commands.push_back(res);
    end
  endfunction

  function automatic void queue_key_event(logic [1:0] act, logic [ROW_W-1:0] r,
                                          logic [COL_W-1:0] c, int unsigned gap);
    key_event_t ev;
    ev.action  = act;
    ev.row     = r;
    ev.column  = c;
    ev.gap_pct = gap;
    pending_events.push_back(ev);
  endfunction

  function automatic void queue_random_key_event(int unsigned gap);
    int unsigned sel;
    logic [1:0]  act;
    sel = $urandom_range(99);
    act = ($urandom_range(99) < 55) ? ACT_PRESS : ACT_RELEASE;
    if (sel < 3)
      queue_key_event(ACT_RELEASE_ALL, ROW_W'($urandom_range(7)), COL_W'($urandom_range(7)), gap);
    else if (sel < 8)
      queue_key_event(ACT_UNDEFINED, ROW_W'($urandom_range(7)), COL_W'($urandom_range(7)), gap);
    else if (sel < 18)
      queue_key_event(act, ROW_W'($urandom_range(7)), COL_W'($urandom_range(7)), gap);
    else if (sel < 55)
      // hot spot so counts climb above one
      queue_key_event(act, ROW_W'($urandom_range(1)), COL_W'($urandom_range(1)), gap);
    else
      queue_key_event(act, ROW_W'($urandom_range(MATRIX_ROWS - 1)),
                      COL_W'($urandom_range(MATRIX_COLUMNS - 1)), gap);
  endfunction

  // driver
  always @(negedge clk_i) begin
    logic next_start;
    next_start = start;
    if (rst_ni) begin
      if (took_event) begin
        void'(pending_events.pop_front());
        next_start = 1'b0;
      end
      if (!next_start && pending_events.size() != 0)
        next_start = ($urandom_range(99) >= pending_events[0].gap_pct);
      if (next_start) begin
        action_i <= pending_events[0].action;
        row_i    <= pending_events[0].row;
        column_i <= pending_events[0].column;
      end
      start <= next_start;
    end
  end

  // monitor and prediction
  always @(posedge clk_i) begin
    latch_result_t want;
    if (!rst_ni) begin
      took_event <= 1'b0;
      for (int i = 0; i < NUM_POS; i++) hold_count[i] = '0;
    end else begin
      if (strobe_o) begin
        if (expected_commands.size() == 0) begin
          $error("unexpected transaction: address %0d close %0d", switch_address_o, close_o);
          error_count++;
        end else begin
          want = expected_commands.pop_front();
          if (accepted_o !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, accepted_o);
            error_count++;
          end
          if (write_valid_o !== want.write_valid) begin
            $error("write_valid: expected %0d, actual %0d", want.write_valid, write_valid_o);
            error_count++;
          end
          if (switch_address_o !== want.switch_address) begin
            $error("switch_address: expected %0d, actual %0d", want.switch_address,
                   switch_address_o);
            error_count++;
          end
          if (close_o !== want.close) begin
            $error("close: expected %0d, actual %0d", want.close, close_o);
            error_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            error_count++;
          end
        end
      end
      if (start && !busy) predict_latch_commands(action_i, row_i, column_i);
      took_event <= start && !busy;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    // directed
    queue_key_event(ACT_PRESS, 3'd0, 3'd0, 0);
    queue_key_event(ACT_PRESS, 3'd0, 3'd0, 0);
    queue_key_event(ACT_RELEASE, 3'd0, 3'd0, 0);
    queue_key_event(ACT_RELEASE, 3'd0, 3'd0, 50);
    queue_key_event(ACT_RELEASE, 3'd0, 3'd0, 0);
    queue_key_event(ACT_PRESS, 3'd5, 3'd3, 0);
    queue_key_event(ACT_PRESS, 3'd6, 3'd0, 0);
    queue_key_event(ACT_PRESS, 3'd7, 3'd7, 50);
    queue_key_event(ACT_RELEASE, 3'd0, 3'd4, 0);
    queue_key_event(ACT_RELEASE, 3'd5, 3'd7, 0);
    queue_key_event(ACT_RELEASE, 3'd5, 3'd3, 0);
    queue_key_event(ACT_UNDEFINED, 3'd7, 3'd7, 0);
    queue_key_event(ACT_UNDEFINED, 3'd0, 3'd0, 50);
    queue_key_event(ACT_PRESS, 3'd2, 3'd1, 0);
    queue_key_event(ACT_PRESS, 3'd3, 3'd2, 0);
    queue_key_event(ACT_RELEASE_ALL, 3'd7, 3'd7, 0);
    queue_key_event(ACT_RELEASE, 3'd2, 3'd1, 0);
    queue_key_event(ACT_PRESS, 3'd2, 3'd1, 0);
    queue_key_event(ACT_RELEASE_ALL, 3'd0, 3'd0, 0);
    queue_key_event(ACT_RELEASE_ALL, 3'd5, 3'd2, 0);
    queue_key_event(ACT_PRESS, 3'd4, 3'd0, 0);
    // count climbs and falls back, the last release opens
    repeat (3) queue_key_event(ACT_PRESS, 3'd1, 3'd2, 0);
    repeat (3) queue_key_event(ACT_RELEASE, 3'd1, 3'd2, 0);
    repeat (48) queue_random_key_event(33);
    repeat (48) queue_random_key_event(75);
    repeat (48) queue_random_key_event(0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_events.size() != 0 || start) @(posedge clk_i);
    while (expected_commands.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rch_pkg.sv
rtl/rch_ctrl.sv
rtl/rch_datapath.sv
rtl/refcounted_crosspoint_hold_unit.sv
tb/sv/refcounted_crosspoint_hold_unit_tb.sv
